[src/assert_macros.svh]
// Assertion macros shared by the reassembler RTL.
// Included by files that carry concurrent checks; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define TSR_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
	else $error("reassembler check failed");
`define TSR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
	else $error("reassembler sequence check failed");
`else
`define TSR_ASSERT(lbl, clk, rst_n, prop)
`define TSR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

[src/tsr_pkg.sv]
// Shared constants and controller/datapath interface types for the reassembler.
// No dependencies.
package tsr_pkg;

	localparam int CAPACITY = 64;
	localparam int SLOT_W   = $clog2(CAPACITY);
	localparam int CNT_W    = 7;
	localparam int IDX_W    = 64;
	localparam int GRP      = 8;
	localparam int NGRP     = (CAPACITY + GRP - 1) / GRP;
	localparam int PART_W   = $clog2(GRP + 1);
	localparam logic [IDX_W-1:0] NO_END = 64'hFFFF_FFFF_FFFF_FFFF;

	typedef struct packed {
		logic capture;
		logic prep;
		logic count;
		logic sum;
		logic emit;
		logic emit_byte;
		logic emit_last;
	} cmd_t;

	typedef struct packed {
		logic can_emit;
		logic next_can;
	} sts_t;

endpackage

[src/tcp_byte_stream_reassembler_core.sv]
// Top level of the stream byte reassembler: controller plus datapath.
// Depends on tsr_pkg, tsr_ctrl, tsr_datapath and assert_macros.svh.
//
// A beat is taken when start is high while busy is low. The block then works
// through the beat in order (capture, window trim and store, held byte counting
// per group, then the sum of the groups) and then releases one in-order byte per
// cycle from the ring store while bytes stay contiguous, giving at
// least one result per beat; the drain rate is set by the single read port of the
// store. Each result is shown for one cycle with result_valid high, starting
// the cycle after the first drain step, and must be taken then: there is no
// way to hold results off. The final result of each beat has last_of_run set
// and carries the status fields. No clearing pass is needed after reset.
`include "assert_macros.svh"

module tcp_byte_stream_reassembler_core (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	output logic                       busy,
	input  logic [tsr_pkg::IDX_W-1:0]  stream_index,
	input  logic [7:0]                 data_byte,
	input  logic                       has_byte,
	input  logic                       end_here,
	input  logic [tsr_pkg::CNT_W-1:0]  downstream_used,
	output logic                       result_valid,
	output logic                       byte_valid,
	output logic [7:0]                 out_byte,
	output logic                       last_of_run,
	output logic                       stream_ended,
	output logic [tsr_pkg::CNT_W-1:0]  held_count,
	output logic                       window_empty
);

	tsr_pkg::cmd_t cmd;
	tsr_pkg::sts_t sts;

	tsr_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.sts    (sts),
		.cmd    (cmd)
	);

	tsr_datapath u_datapath (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.sts             (sts),
		.stream_index    (stream_index),
		.data_byte       (data_byte),
		.has_byte        (has_byte),
		.end_here        (end_here),
		.downstream_used (downstream_used),
		.result_valid    (result_valid),
		.byte_valid      (byte_valid),
		.out_byte        (out_byte),
		.last_of_run     (last_of_run),
		.stream_ended    (stream_ended),
		.held_count      (held_count),
		.window_empty    (window_empty)
	);

	`TSR_ASSERT_NEXT(a_accept_busy, clk, arst_n, start && !busy, busy)
	`TSR_ASSERT_NEXT(a_run_continues, clk, arst_n, result_valid && !last_of_run, result_valid)
	`TSR_ASSERT(a_status_last, clk, arst_n, result_valid && !byte_valid |-> last_of_run)
	`TSR_ASSERT(a_busy_in_run, clk, arst_n, result_valid && !last_of_run |-> busy)

endmodule

[src/tsr_ctrl.sv]
// Sequencing state machine of the reassembler.
// Depends on tsr_pkg for the command and status types.
module tsr_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	output logic          busy,
	input  tsr_pkg::sts_t sts,
	output tsr_pkg::cmd_t cmd
);

	typedef enum logic [4:0] {
		ST_IDLE  = 5'b00001,
		ST_PREP  = 5'b00010,
		ST_CNT   = 5'b00100,
		ST_SUM   = 5'b01000,
		ST_DRAIN = 5'b10000
	} state_t;

	state_t state_q;
	state_t state_d;

	always_comb begin
		state_d = state_q;
		cmd = '0;
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					cmd.capture = 1'b1;
					state_d = ST_PREP;
				end
			end
			ST_PREP: begin
				cmd.prep = 1'b1;
				state_d = ST_CNT;
			end
			ST_CNT: begin
				cmd.count = 1'b1;
				state_d = ST_SUM;
			end
			ST_SUM: begin
				cmd.sum = 1'b1;
				state_d = ST_DRAIN;
			end
			ST_DRAIN: begin
				cmd.emit = 1'b1;
				cmd.emit_byte = sts.can_emit;
				cmd.emit_last = !sts.can_emit || !sts.next_can;
				if (cmd.emit_last) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign busy = (state_q != ST_IDLE);

endmodule

[src/tsr_datapath.sv]
// Datapath of the reassembler: ring store, valid marks, stream pointers,
// held-byte count and result registers. Depends on tsr_pkg.
module tsr_datapath (
	input  logic                       clk,
	input  logic                       arst_n,
	input  tsr_pkg::cmd_t              cmd,
	output tsr_pkg::sts_t              sts,
	input  logic [tsr_pkg::IDX_W-1:0]  stream_index,
	input  logic [7:0]                 data_byte,
	input  logic                       has_byte,
	input  logic                       end_here,
	input  logic [tsr_pkg::CNT_W-1:0]  downstream_used,
	output logic                       result_valid,
	output logic                       byte_valid,
	output logic [7:0]                 out_byte,
	output logic                       last_of_run,
	output logic                       stream_ended,
	output logic [tsr_pkg::CNT_W-1:0]  held_count,
	output logic                       window_empty
);

	logic [tsr_pkg::IDX_W-1:0]    idx_q;
	logic [7:0]                   data_q;
	logic                         has_q;
	logic                         end_here_q;
	logic [tsr_pkg::CNT_W-1:0]    used_q;

	logic [7:0]                   mem [tsr_pkg::CAPACITY];
	logic [7:0]                   rd_q;

	logic [tsr_pkg::CAPACITY-1:0] valid_q;
	logic [tsr_pkg::SLOT_W-1:0]   head_q;
	logic [tsr_pkg::IDX_W-1:0]    ne_q;
	logic [tsr_pkg::IDX_W-1:0]    end_pos_q;
	logic [tsr_pkg::CNT_W-1:0]    remaining_q;
	logic [tsr_pkg::PART_W-1:0]   part_q [tsr_pkg::NGRP];
	logic [tsr_pkg::CNT_W-1:0]    pop_q;

	logic [tsr_pkg::CNT_W-1:0]    win;
	logic [tsr_pkg::CAPACITY-1:0] clr_mask;
	logic [tsr_pkg::IDX_W:0]      diff_ext;
	logic                         ok_store;
	logic [tsr_pkg::SLOT_W:0]     slot_sum;
	logic [tsr_pkg::SLOT_W-1:0]   store_slot;
	logic [tsr_pkg::SLOT_W-1:0]   head_inc;
	logic [tsr_pkg::SLOT_W-1:0]   head_d;
	logic [tsr_pkg::IDX_W-1:0]    ne_d;
	logic [tsr_pkg::CNT_W-1:0]    pop_sum;

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			idx_q      <= stream_index;
			data_q     <= data_byte;
			has_q      <= has_byte;
			end_here_q <= end_here;
			used_q     <= downstream_used;
		end
	end

	always_comb begin
		logic [tsr_pkg::SLOT_W:0] off;
		if (used_q >= tsr_pkg::CNT_W'(tsr_pkg::CAPACITY)) begin
			win = '0;
		end else begin
			win = tsr_pkg::CNT_W'(tsr_pkg::CAPACITY) - used_q;
		end
		for (int k = 0; k < tsr_pkg::CAPACITY; k++) begin
			if (tsr_pkg::SLOT_W'(k) >= head_q) begin
				off = (tsr_pkg::SLOT_W+1)'(k) - {1'b0, head_q};
			end else begin
				off = (tsr_pkg::SLOT_W+1)'(k + tsr_pkg::CAPACITY) - {1'b0, head_q};
			end
			clr_mask[k] = (tsr_pkg::CNT_W'(off) >= win);
		end
	end

	assign diff_ext = {1'b0, idx_q} - {1'b0, ne_q};
	assign ok_store = has_q && !diff_ext[tsr_pkg::IDX_W]
		&& (diff_ext[tsr_pkg::IDX_W-1:0] < {{(tsr_pkg::IDX_W-tsr_pkg::CNT_W){1'b0}}, win});
	assign slot_sum = {1'b0, head_q} + {1'b0, diff_ext[tsr_pkg::SLOT_W-1:0]};
	assign store_slot = (slot_sum >= (tsr_pkg::SLOT_W+1)'(tsr_pkg::CAPACITY))
		? tsr_pkg::SLOT_W'(slot_sum - (tsr_pkg::SLOT_W+1)'(tsr_pkg::CAPACITY))
		: slot_sum[tsr_pkg::SLOT_W-1:0];

	assign head_inc = (head_q == tsr_pkg::SLOT_W'(tsr_pkg::CAPACITY - 1))
		? '0 : head_q + tsr_pkg::SLOT_W'(1);
	assign head_d = cmd.emit_byte ? head_inc : head_q;
	assign ne_d   = ne_q + tsr_pkg::IDX_W'(cmd.emit_byte);

	assign sts.can_emit = (remaining_q != '0) && valid_q[head_q];
	assign sts.next_can = (remaining_q > tsr_pkg::CNT_W'(1)) && valid_q[head_inc];

	always_ff @(posedge clk) begin
		if (cmd.prep && ok_store) begin
			mem[store_slot] <= data_q;
		end
		rd_q <= mem[head_d];
	end

	always_comb begin
		pop_sum = '0;
		for (int g = 0; g < tsr_pkg::NGRP; g++) begin
			pop_sum = pop_sum + tsr_pkg::CNT_W'(part_q[g]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q     <= '0;
			head_q      <= '0;
			ne_q        <= '0;
			end_pos_q   <= tsr_pkg::NO_END;
			remaining_q <= '0;
			pop_q       <= '0;
		end else begin
			if (cmd.prep) begin
				valid_q <= (valid_q & ~clr_mask)
					| (ok_store ? (tsr_pkg::CAPACITY'(1) << store_slot) : '0);
				remaining_q <= win;
				if (end_here_q) begin
					end_pos_q <= has_q ? idx_q + tsr_pkg::IDX_W'(1) : idx_q;
				end
			end
			if (cmd.sum) begin
				pop_q <= pop_sum;
			end
			if (cmd.emit_byte) begin
				valid_q[head_q] <= 1'b0;
				head_q          <= head_inc;
				ne_q            <= ne_d;
				remaining_q     <= remaining_q - tsr_pkg::CNT_W'(1);
				pop_q           <= pop_q - tsr_pkg::CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.count) begin
			for (int g = 0; g < tsr_pkg::NGRP; g++) begin
				logic [tsr_pkg::PART_W-1:0] acc;
				acc = '0;
				for (int b = 0; b < tsr_pkg::GRP; b++) begin
					if (g * tsr_pkg::GRP + b < tsr_pkg::CAPACITY) begin
						acc = acc + tsr_pkg::PART_W'(valid_q[g * tsr_pkg::GRP + b]);
					end
				end
				part_q[g] <= acc;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid <= 1'b0;
		end else begin
			result_valid <= cmd.emit;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			byte_valid  <= cmd.emit_byte;
			out_byte    <= cmd.emit_byte ? rd_q : 8'h00;
			last_of_run <= cmd.emit_last;
			if (cmd.emit_last) begin
				stream_ended <= (ne_d == end_pos_q);
				held_count   <= pop_q - tsr_pkg::CNT_W'(cmd.emit_byte);
				window_empty <= ((remaining_q - tsr_pkg::CNT_W'(cmd.emit_byte)) == '0);
			end else begin
				stream_ended <= 1'b0;
				held_count   <= '0;
				window_empty <= 1'b0;
			end
		end
	end

endmodule
